>>> rtl/core/vrp_pkg.sv
package vrp_pkg;

  localparam int CoordWidth = 16;
  localparam int AngW = 16;
  localparam int FovW = 15;
  localparam int CenW = 12;
  localparam int ScaW = 10;
  localparam int OutW = 16;
  localparam int FracW = 14;

  localparam int P1W = CoordWidth + AngW;
  localparam int R1W = CoordWidth + 3;
  localparam int P2W = R1W + AngW;
  localparam int R2W = R1W + 3;
  localparam int DenW = R2W + 1;
  localparam int DW = DenW + 8;
  localparam int FW = FovW + 1 + R2W;
  localparam int PW = FW + ScaW + 1;
  localparam int CDW = CenW + 1 + DW;
  localparam int NW = PW + 1;
  localparam int QW = OutW;

  localparam int CfgIdxW = 3;
  localparam int CfgDataW = 16;

  typedef enum logic [CfgIdxW-1:0] {
    RegCos = 3'd0,
    RegSin = 3'd1,
    RegFov = 3'd2,
    RegCenX = 3'd3,
    RegCenY = 3'd4,
    RegScale = 3'd5
  } cfg_reg_e;

endpackage

>>> rtl/core/vertex_rotate_project_top.sv
// Rotates each vertex about Y then X by the configured cosine and sine, then
// projects it in perspective with an exact truncating divide. One vertex is
// accepted per cycle unless the output stalls, which freezes the whole
// pipeline. Each result passes nine transform and numerator stages, a
// sixteen-stage restoring divider (one quotient bit per stage, one per axis)
// and the output register. Configuration writes are always ready; settings
// are read at several stages, so write them only while no vertex is in flight.
module vertex_rotate_project_top (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic signed [vrp_pkg::CoordWidth-1:0] vertex_x_i,
  input  logic signed [vrp_pkg::CoordWidth-1:0] vertex_y_i,
  input  logic signed [vrp_pkg::CoordWidth-1:0] vertex_z_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic signed [vrp_pkg::OutW-1:0] screen_x_o,
  output logic signed [vrp_pkg::OutW-1:0] screen_y_o,
  output logic                         zero_depth_o,
  output logic                         saturated_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [vrp_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [vrp_pkg::CfgDataW-1:0] cfg_data_i
);

  localparam int CW = vrp_pkg::CoordWidth;
  localparam int QW = vrp_pkg::QW;
  localparam int NW = vrp_pkg::NW;
  localparam int DW = vrp_pkg::DW;

  logic signed [vrp_pkg::AngW-1:0] cos_q, sin_q;
  logic [vrp_pkg::FovW-1:0] fov_q;
  logic [vrp_pkg::CenW-1:0] cenx_q, ceny_q;
  logic [vrp_pkg::ScaW-1:0] scale_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cos_q <= 16'sd16384;
      sin_q <= '0;
      fov_q <= 15'd1024;
      cenx_q <= 12'd320;
      ceny_q <= 12'd240;
      scale_q <= 10'd100;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        vrp_pkg::RegCos: cos_q <= $signed(cfg_data_i);
        vrp_pkg::RegSin: sin_q <= $signed(cfg_data_i);
        vrp_pkg::RegFov: fov_q <= cfg_data_i[vrp_pkg::FovW-1:0];
        vrp_pkg::RegCenX: cenx_q <= cfg_data_i[vrp_pkg::CenW-1:0];
        vrp_pkg::RegCenY: ceny_q <= cfg_data_i[vrp_pkg::CenW-1:0];
        vrp_pkg::RegScale: scale_q <= cfg_data_i[vrp_pkg::ScaW-1:0];
        default: ;
      endcase
    end
  end

  logic adv;
  logic out_v_q;
  assign adv = !(out_v_q && out_stall_i);
  assign in_stall_o = !adv;

  logic s1_v_q, s2_v_q, s3_v_q, s4_v_q, s5_v_q, s6_v_q, s7_v_q, s8_v_q, s9_v_q;
  logic [QW-1:0] dv_q;

  // stage 1: first rotation products
  logic signed [vrp_pkg::P1W-1:0] p_cx_q, p_sz_q, p_sx_q, p_cz_q;
  logic signed [CW-1:0] y_s1_q;
  // stage 2: rotation about y
  logic signed [vrp_pkg::R1W-1:0] x1_q, z1_q, y_s2_q;
  logic signed [vrp_pkg::P1W:0] sx1_d, sz1_d;
  // stage 3: second rotation products
  logic signed [vrp_pkg::P2W-1:0] p_cy_q, p_sz1_q, p_sy_q, p_cz1_q;
  logic signed [vrp_pkg::R1W-1:0] x1_s3_q;
  // stage 4: rotation about x and depth
  logic signed [vrp_pkg::P2W:0] sy2_d, sz2_d;
  logic signed [vrp_pkg::R2W-1:0] x_s4_q, y2_q;
  logic signed [vrp_pkg::DenW-1:0] den_q;
  // stage 5
  logic signed [vrp_pkg::FW-1:0] fx_q, fy_q;
  logic signed [DW-1:0] d_q;
  logic z_s5_q;
  // stage 6
  logic signed [vrp_pkg::PW-1:0] px_q, py_q;
  logic signed [vrp_pkg::CDW-1:0] cdx_q, cdy_q;
  logic signed [DW-1:0] d_s6_q;
  logic z_s6_q;
  // stage 7
  logic signed [NW-1:0] nx_q, ny_q;
  logic signed [DW-1:0] d_s7_q;
  logic z_s7_q;
  // stage 8: magnitudes
  logic [NW-1:0] mx_q, my_q;
  logic [DW-1:0] md_q;
  logic negx_s8_q, negy_s8_q, z_s8_q;
  // stage 9: overflow check
  logic [NW-1:0] mx9_q, my9_q;
  logic [DW-1:0] md9_q;
  logic negx9_q, negy9_q, z9_q, ovx9_q, ovy9_q;
  // divider lanes
  logic [NW-1:0] rx_q [QW], ry_q [QW];
  logic [DW-1:0] dd_q [QW];
  logic [QW-1:0] qx_q [QW], qy_q [QW];
  logic [QW-1:0] negx_q, negy_q, zf_q, ovx_q, ovy_q;

  assign sx1_d = (vrp_pkg::P1W+1)'(p_cx_q) - (vrp_pkg::P1W+1)'(p_sz_q);
  assign sz1_d = (vrp_pkg::P1W+1)'(p_sx_q) + (vrp_pkg::P1W+1)'(p_cz_q);
  assign sy2_d = (vrp_pkg::P2W+1)'(p_cy_q) - (vrp_pkg::P2W+1)'(p_sz1_q);
  assign sz2_d = (vrp_pkg::P2W+1)'(p_sy_q) + (vrp_pkg::P2W+1)'(p_cz1_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0; s2_v_q <= 1'b0; s3_v_q <= 1'b0; s4_v_q <= 1'b0;
      s5_v_q <= 1'b0; s6_v_q <= 1'b0; s7_v_q <= 1'b0; s8_v_q <= 1'b0;
      s9_v_q <= 1'b0; dv_q <= '0;
    end else if (adv) begin
      s1_v_q <= in_valid_i; s2_v_q <= s1_v_q; s3_v_q <= s2_v_q;
      s4_v_q <= s3_v_q; s5_v_q <= s4_v_q; s6_v_q <= s5_v_q;
      s7_v_q <= s6_v_q; s8_v_q <= s7_v_q; s9_v_q <= s8_v_q;
      dv_q <= {dv_q[QW-2:0], s9_v_q};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      p_cx_q <= cos_q * vertex_x_i;
      p_sz_q <= sin_q * vertex_z_i;
      p_sx_q <= sin_q * vertex_x_i;
      p_cz_q <= cos_q * vertex_z_i;
      y_s1_q <= vertex_y_i;

      x1_q <= sx1_d[vrp_pkg::P1W:vrp_pkg::FracW];
      z1_q <= sz1_d[vrp_pkg::P1W:vrp_pkg::FracW];
      y_s2_q <= vrp_pkg::R1W'(y_s1_q);

      p_cy_q <= cos_q * y_s2_q;
      p_sz1_q <= sin_q * z1_q;
      p_sy_q <= sin_q * y_s2_q;
      p_cz1_q <= cos_q * z1_q;
      x1_s3_q <= x1_q;

      x_s4_q <= vrp_pkg::R2W'(x1_s3_q);
      y2_q <= sy2_d[vrp_pkg::P2W:vrp_pkg::FracW];
      den_q <= $signed({{(vrp_pkg::DenW-vrp_pkg::FovW){1'b0}}, fov_q})
             + vrp_pkg::DenW'($signed(sz2_d[vrp_pkg::P2W:vrp_pkg::FracW]));

      fx_q <= $signed({1'b0, fov_q}) * x_s4_q;
      fy_q <= $signed({1'b0, fov_q}) * y2_q;
      d_q <= {den_q, 8'd0};
      z_s5_q <= (den_q == '0);

      px_q <= fx_q * $signed({1'b0, scale_q});
      py_q <= fy_q * $signed({1'b0, scale_q});
      cdx_q <= $signed({1'b0, cenx_q}) * d_q;
      cdy_q <= $signed({1'b0, ceny_q}) * d_q;
      d_s6_q <= d_q;
      z_s6_q <= z_s5_q;

      nx_q <= NW'(cdx_q) + NW'(px_q);
      ny_q <= NW'(cdy_q) + NW'(py_q);
      d_s7_q <= d_s6_q;
      z_s7_q <= z_s6_q;

      mx_q <= nx_q[NW-1] ? NW'(-nx_q) : NW'(nx_q);
      my_q <= ny_q[NW-1] ? NW'(-ny_q) : NW'(ny_q);
      md_q <= d_s7_q[DW-1] ? DW'(-d_s7_q) : DW'(d_s7_q);
      negx_s8_q <= nx_q[NW-1] ^ d_s7_q[DW-1];
      negy_s8_q <= ny_q[NW-1] ^ d_s7_q[DW-1];
      z_s8_q <= z_s7_q;

      mx9_q <= mx_q; my9_q <= my_q; md9_q <= md_q;
      negx9_q <= negx_s8_q; negy9_q <= negy_s8_q; z9_q <= z_s8_q;
      ovx9_q <= ((NW+1)'(mx_q) >= (NW+1)'({md_q, {QW{1'b0}}}));
      ovy9_q <= ((NW+1)'(my_q) >= (NW+1)'({md_q, {QW{1'b0}}}));
    end
  end

  // restoring divide, one quotient bit per stage, msb first
  logic [NW:0] tx_d [QW], ty_d [QW];
  logic [NW-1:0] rin_x [QW], rin_y [QW];
  logic [DW-1:0] din [QW];
  logic [QW-1:0] qin_x [QW], qin_y [QW];

  always_comb begin
    for (int j = 0; j < QW; j++) begin
      if (j == 0) begin
        rin_x[j] = mx9_q; rin_y[j] = my9_q; din[j] = md9_q;
        qin_x[j] = '0; qin_y[j] = '0;
      end else begin
        rin_x[j] = rx_q[j-1]; rin_y[j] = ry_q[j-1]; din[j] = dd_q[j-1];
        qin_x[j] = qx_q[j-1]; qin_y[j] = qy_q[j-1];
      end
      tx_d[j] = (NW+1)'(rin_x[j]) - ((NW+1)'(din[j]) << (QW-1-j));
      ty_d[j] = (NW+1)'(rin_y[j]) - ((NW+1)'(din[j]) << (QW-1-j));
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int j = 0; j < QW; j++) begin
        dd_q[j] <= din[j];
        rx_q[j] <= tx_d[j][NW] ? rin_x[j] : tx_d[j][NW-1:0];
        ry_q[j] <= ty_d[j][NW] ? rin_y[j] : ty_d[j][NW-1:0];
        qx_q[j] <= {qin_x[j][QW-2:0], !tx_d[j][NW]};
        qy_q[j] <= {qin_y[j][QW-2:0], !ty_d[j][NW]};
      end
      negx_q <= {negx_q[QW-2:0], negx9_q};
      negy_q <= {negy_q[QW-2:0], negy9_q};
      zf_q <= {zf_q[QW-2:0], z9_q};
      ovx_q <= {ovx_q[QW-2:0], ovx9_q};
      ovy_q <= {ovy_q[QW-2:0], ovy9_q};
    end
  end

  // sign, clamp and output register
  logic [QW-1:0] qfx, qfy;
  logic satx_d, saty_d;
  logic signed [QW-1:0] sx_d, sy_d;
  logic signed [QW-1:0] sx_q, sy_q;
  logic zero_q, sat_q;

  assign qfx = qx_q[QW-1];
  assign qfy = qy_q[QW-1];

  always_comb begin
    if (negx_q[QW-1]) begin
      satx_d = ovx_q[QW-1] || (qfx[QW-1] && (qfx[QW-2:0] != '0));
      sx_d = satx_d ? {1'b1, {(QW-1){1'b0}}} : $signed(-qfx);
    end else begin
      satx_d = ovx_q[QW-1] || qfx[QW-1];
      sx_d = satx_d ? {1'b0, {(QW-1){1'b1}}} : $signed(qfx);
    end
    if (negy_q[QW-1]) begin
      saty_d = ovy_q[QW-1] || (qfy[QW-1] && (qfy[QW-2:0] != '0));
      sy_d = saty_d ? {1'b1, {(QW-1){1'b0}}} : $signed(-qfy);
    end else begin
      saty_d = ovy_q[QW-1] || qfy[QW-1];
      sy_d = saty_d ? {1'b0, {(QW-1){1'b1}}} : $signed(qfy);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (adv) begin
      out_v_q <= dv_q[QW-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      zero_q <= zf_q[QW-1];
      if (zf_q[QW-1]) begin
        sx_q <= $signed(QW'(cenx_q));
        sy_q <= $signed(QW'(ceny_q));
        sat_q <= 1'b0;
      end else begin
        sx_q <= sx_d;
        sy_q <= sy_d;
        sat_q <= satx_d || saty_d;
      end
    end
  end

  assign out_valid_o = out_v_q;
  assign screen_x_o = sx_q;
  assign screen_y_o = sy_q;
  assign zero_depth_o = zero_q;
  assign saturated_o = sat_q;

  a_accept_enters : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> s1_v_q)
    else $error("accepted beat did not enter the pipeline");
  a_zero_no_sat : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && zero_depth_o) |-> !saturated_o)
    else $error("zero depth result flagged as saturated");
  a_zero_center : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && zero_depth_o && !cfg_valid_i && !$past(cfg_valid_i))
      |-> (screen_x_o == $signed(QW'(cenx_q))))
    else $error("zero depth result is not the center");
  a_stall_freeze : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(screen_x_o)
      && $stable(dv_q)))
    else $error("pipeline moved under output stall");

endmodule

>>> tb/sv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

  typedef struct packed {
    logic signed [15:0] sx;
    logic signed [15:0] sy;
    logic               zero;
    logic               sat;
  } pixel_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic signed [vrp_pkg::CoordWidth-1:0] vertex_x_i = '0;
  logic signed [vrp_pkg::CoordWidth-1:0] vertex_y_i = '0;
  logic signed [vrp_pkg::CoordWidth-1:0] vertex_z_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic signed [vrp_pkg::OutW-1:0] screen_x_o;
  logic signed [vrp_pkg::OutW-1:0] screen_y_o;
  logic zero_depth_o;
  logic saturated_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [vrp_pkg::CfgIdxW-1:0] cfg_index_i = '0;
  logic [vrp_pkg::CfgDataW-1:0] cfg_data_i = '0;

  vertex_rotate_project_top dut (.*);

  always #5 clk_i = ~clk_i;

  // projection settings as the block currently holds them
  longint cur_cos = 16384, cur_sin = 0, cur_fov = 1024;
  longint cur_cx = 320, cur_cy = 240, cur_scale = 100;

  pixel_t pending_pixels[$];
  int     send_idle_pct = 0;
  int     recv_idle_pct = 0;
  int     hold_cycles = 0;
  int     hold_req = 0;
  int     hold_seen = 0;
  int     mismatches = 0;
  int     pixels_seen = 0;
  int     vertices_sent = 0;
  int     n_zero = 0;
  int     n_sat = 0;

  function automatic longint floor_shift14(longint v);
    return v >>> 14;
  endfunction

  function automatic longint clamp_px(longint v, ref bit sat);
    if (v > 32767) begin
      sat = 1'b1;
      return 32767;
    end
    if (v < -32768) begin
      sat = 1'b1;
      return -32768;
    end
    return v;
  endfunction

  function automatic pixel_t project_vertex(longint x, longint y, longint z);
    longint x1, z1, y2, z2, den, d, px, py;
    bit sat;
    pixel_t p;
    sat = 1'b0;
    x1 = floor_shift14(cur_cos * x - cur_sin * z);
    z1 = floor_shift14(cur_sin * x + cur_cos * z);
    y2 = floor_shift14(cur_cos * y - cur_sin * z1);
    z2 = floor_shift14(cur_sin * y + cur_cos * z1);
    den = cur_fov + z2;
    p.zero = (den == 0);
    if (den == 0) begin
      px = cur_cx;
      py = cur_cy;
    end else begin
      d = den * 256;
      px = clamp_px((cur_cx * d + cur_fov * x1 * cur_scale) / d, sat);
      py = clamp_px((cur_cy * d + cur_fov * y2 * cur_scale) / d, sat);
    end
    p.sx = px[15:0];
    p.sy = py[15:0];
    p.sat = sat;
    return p;
  endfunction

  task automatic write_reg(vrp_pkg::cfg_reg_e idx, longint val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val[15:0];
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      vrp_pkg::RegCos:   cur_cos = longint'(signed'(val[15:0]));
      vrp_pkg::RegSin:   cur_sin = longint'(signed'(val[15:0]));
      vrp_pkg::RegFov:   cur_fov = val & 16'h7fff;
      vrp_pkg::RegCenX:  cur_cx = val & 16'h0fff;
      vrp_pkg::RegCenY:  cur_cy = val & 16'h0fff;
      vrp_pkg::RegScale: cur_scale = val & 16'h03ff;
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic send_vertex(logic [15:0] x, logic [15:0] y, logic [15:0] z);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    vertex_x_i <= x;
    vertex_y_i <= y;
    vertex_z_i <= z;
    do @(posedge clk_i); while (in_stall_o);
    pending_pixels.push_back(project_vertex(longint'(signed'(x)),
                                            longint'(signed'(y)),
                                            longint'(signed'(z))));
    vertices_sent++;
  endtask

  task automatic drain;
    in_valid_i <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);
  endtask

  task automatic set_angle(longint c, longint s);
    write_reg(vrp_pkg::RegCos, c);
    write_reg(vrp_pkg::RegSin, s);
  endtask

  always @(posedge clk_i) begin
    if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_cycles <= 199;
      out_stall_i <= 1'b1;
    end else if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    pixel_t exp_p;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      pixels_seen++;
      if (zero_depth_o) n_zero++;
      if (saturated_o) n_sat++;
      if (pending_pixels.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected pixel beat at %0t", $realtime);
      end else begin
        exp_p = pending_pixels.pop_front();
        if (screen_x_o !== exp_p.sx || screen_y_o !== exp_p.sy ||
            zero_depth_o !== exp_p.zero || saturated_o !== exp_p.sat) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp x=%0d y=%0d z=%b s=%b got x=%0d y=%0d z=%b s=%b",
                     exp_p.sx, exp_p.sy, exp_p.zero, exp_p.sat,
                     screen_x_o, screen_y_o, zero_depth_o, saturated_o);
        end
      end
    end
  end

  task automatic test_directed;
    send_vertex(16'h0000, 16'h0000, 16'h0000);
    send_vertex(16'h7fff, 16'h7fff, 16'h7fff);
    send_vertex(16'h8000, 16'h8000, 16'h8000);
    send_vertex(16'h7fff, 16'h8000, 16'h0000);
    send_vertex(16'h0100, 16'hff00, 16'hfc00);
    send_vertex(16'h0100, 16'h0100, 16'hfc01);
    send_vertex(16'hffff, 16'h0001, 16'hfbff);
    drain();
    set_angle(11585, 11585);
    write_reg(vrp_pkg::RegFov, 32767);
    write_reg(vrp_pkg::RegCenX, 4095);
    write_reg(vrp_pkg::RegCenY, 0);
    write_reg(vrp_pkg::RegScale, 1023);
    send_vertex(16'h7fff, 16'h8000, 16'h1234);
    send_vertex(16'h8000, 16'h7fff, 16'h8000);
    send_vertex(16'h0000, 16'h0000, 16'h8001);
    drain();
    set_angle(-16384, 16384);
    write_reg(vrp_pkg::RegFov, 0);
    write_reg(vrp_pkg::RegScale, 0);
    write_reg(vrp_pkg::RegCenX, 0);
    write_reg(vrp_pkg::RegCenY, 4095);
    send_vertex(16'h0000, 16'h0000, 16'h0000);
    send_vertex(16'h0123, 16'h0456, 16'hf000);
    send_vertex(16'hffff, 16'hffff, 16'hffff);
    drain();
    set_angle(-32768, 32767);
    write_reg(vrp_pkg::RegFov, 1);
    write_reg(vrp_pkg::RegScale, 1);
    send_vertex(16'h7fff, 16'h8000, 16'h7fff);
    send_vertex(16'h0000, 16'h0000, 16'h0000);
    drain();
  endtask

  task automatic random_vertex;
    logic [15:0] x, y, z;
    x = 16'($urandom);
    y = 16'($urandom);
    z = 16'($urandom);
    if ($urandom_range(3) == 0) begin
      x = 16'($urandom_range(511) - 256);
      y = 16'($urandom_range(511) - 256);
      z = 16'($urandom_range(511) - 256);
    end
    if ($urandom_range(15) == 0 && cur_cos == 16384 && cur_sin == 0)
      z = 16'(-cur_fov);
    send_vertex(x, y, z);
  endtask

  task automatic random_settings;
    longint a;
    a = $urandom_range(3);
    if (a == 0) set_angle(16384, 0);
    else if (a == 1) set_angle($urandom_range(32768) - 16384, $urandom_range(32768) - 16384);
    else set_angle($urandom_range(65535), $urandom_range(65535));
    write_reg(vrp_pkg::RegFov,
              $urandom_range(3) == 0 ? $urandom_range(32767) : $urandom_range(2048));
    write_reg(vrp_pkg::RegCenX, $urandom_range(4095));
    write_reg(vrp_pkg::RegCenY, $urandom_range(4095));
    write_reg(vrp_pkg::RegScale, $urandom_range(1023));
  endtask

  task automatic test_random(int sp, int rp, int n);
    send_idle_pct = sp;
    recv_idle_pct = rp;
    for (int i = 0; i < n; i++) begin
      if (i % 60 == 0) begin
        drain();
        random_settings();
      end
      random_vertex();
    end
    drain();
  endtask

  task automatic test_backpressure;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_req <= hold_req + 1;
    for (int i = 0; i < 60; i++) random_vertex();
    drain();
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random(25, 76, 180);
    test_random(76, 25, 150);
    test_backpressure();
    test_random(0, 0, 150);
    $display("sent %0d vertices over several angle and projection settings,", vertices_sent);
    $display("checked %0d pixels (%0d zero depth, %0d clamped)", pixels_seen, n_zero, n_sat);
    if (mismatches == 0 && pending_pixels.size() == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("tb_top: errors");
    $finish;
  end
endmodule
